FILE: hw/rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types, character codes and phase/status codes for the bracket
// literal scanner.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int DEF_MAX_CODE_LEVELS = 15;
  localparam int DEF_MAX_PLAIN_DEPTH = 255;

  localparam logic [7:0] CH_LBR = 8'h5B;  // '['
  localparam logic [7:0] CH_RBR = 8'h5D;  // ']'
  localparam logic [7:0] CH_BSL = 8'h5C;  // backslash
  localparam logic [7:0] CH_HASH = 8'h23; // '#'
  localparam logic [7:0] CH_NL = 8'h0A;   // newline
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PROBE = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNBALANCED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       closes;
    logic [1:0] status;
  } out_item_t;

  // fixed-width part of the scanner state
  typedef struct packed {
    logic [1:0] phase;
    logic       escaping;
    logic       in_comment;
  } flags_t;

endpackage

FILE: hw/rtl/bls_step.sv
// ----------------------------------------------------------------------------
// bls_step
// Next-state and result logic for one byte of the scanner.
// ----------------------------------------------------------------------------
module bls_step
  import bls_pkg::*;
#(
  parameter int MAX_CODE_LEVELS = DEF_MAX_CODE_LEVELS,
  parameter int MAX_PLAIN_DEPTH = DEF_MAX_PLAIN_DEPTH,
  localparam int CW = $clog2(MAX_CODE_LEVELS + 1),
  localparam int PW = $clog2(MAX_PLAIN_DEPTH + 1)
) (
  input  in_item_t        item,
  input  flags_t          flags,
  input  logic [CW-1:0]   code_levels,
  input  logic [PW-1:0]   plain_depth,
  output flags_t          flags_next,
  output logic [CW-1:0]   code_levels_next,
  output logic [PW-1:0]   plain_depth_next,
  output logic            res_valid,
  output out_item_t       res
);

  localparam logic [CW-1:0] CODE_MAX = CW'(MAX_CODE_LEVELS);
  localparam logic [PW-1:0] PLAIN_MAX = PW'(MAX_PLAIN_DEPTH);

  logic [7:0] ch;
  logic       blank;
  logic       do_plain;
  logic [PW-1:0] depth;
  logic [PW-1:0] depth_dec;
  logic       fail;
  logic [1:0] fail_status;
  logic       clear;

  assign ch = item.ch;
  assign blank = (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_NL) || (ch == CH_VT)
              || (ch == CH_FF) || (ch == CH_CR);
  // a probed level that turns out plain starts at depth one
  assign depth = (flags.phase == PH_PROBE) ? PW'(1) : plain_depth;
  assign depth_dec = (depth != '0) ? depth - PW'(1) : '0;

  always_comb begin
    flags_next = flags;
    code_levels_next = code_levels;
    plain_depth_next = plain_depth;
    res_valid = 1'b0;
    res.out_char = ch;
    res.closes = 1'b0;
    res.status = ST_OK;
    do_plain = 1'b0;
    fail = 1'b0;
    fail_status = ST_OK;
    clear = 1'b0;

    if (item.at_end) begin
      if (flags.phase != PH_IDLE) begin
        fail = 1'b1;
        fail_status = ST_UNBALANCED;
      end
    end else begin
      unique case (flags.phase)
        PH_IDLE: begin
          if (ch == CH_LBR) begin
            clear = 1'b1;
            res_valid = 1'b1;
          end
        end
        PH_PROBE: begin
          if (blank) begin
            res_valid = 1'b1;
            if (ch == CH_NL) begin
              if (code_levels == CODE_MAX) begin
                fail = 1'b1;
                fail_status = ST_OVERFLOW;
              end else begin
                code_levels_next = code_levels + CW'(1);
                flags_next.phase = PH_BODY;
              end
            end
          end else begin
            flags_next.phase = PH_BODY;
            do_plain = 1'b1;
          end
        end
        PH_BODY: begin
          if (flags.escaping) begin
            if (ch != CH_BSL) flags_next.escaping = 1'b0;
            res_valid = 1'b1;
          end else if (plain_depth != '0) begin
            do_plain = 1'b1;
          end else if (flags.in_comment) begin
            if (ch == CH_NL) flags_next.in_comment = 1'b0;
            res_valid = 1'b1;
          end else if (ch == CH_BSL) begin
            flags_next.escaping = 1'b1;
          end else if (ch == CH_HASH) begin
            flags_next.in_comment = 1'b1;
            res_valid = 1'b1;
          end else if (ch == CH_LBR) begin
            flags_next.phase = PH_PROBE;
            res_valid = 1'b1;
          end else if (ch == CH_RBR) begin
            res_valid = 1'b1;
            if (code_levels <= CW'(1)) begin
              clear = 1'b1;
              res.closes = 1'b1;
            end else begin
              code_levels_next = code_levels - CW'(1);
            end
          end else begin
            res_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // plain bracket counting, shared by the probe exit and plain bodies
    if (do_plain) begin
      plain_depth_next = depth;
      if (ch == CH_BSL) begin
        flags_next.escaping = 1'b1;
      end else if (ch == CH_LBR) begin
        res_valid = 1'b1;
        if (depth == PLAIN_MAX) begin
          fail = 1'b1;
          fail_status = ST_OVERFLOW;
        end else begin
          plain_depth_next = depth + PW'(1);
        end
      end else if (ch == CH_RBR) begin
        res_valid = 1'b1;
        plain_depth_next = depth_dec;
        if (depth_dec == '0 && code_levels == '0) begin
          clear = 1'b1;
          res.closes = 1'b1;
        end
      end else begin
        res_valid = 1'b1;
      end
    end

    if (clear || fail) begin
      flags_next.phase = PH_IDLE;
      flags_next.escaping = 1'b0;
      flags_next.in_comment = 1'b0;
      code_levels_next = '0;
      plain_depth_next = '0;
    end
    // opening bracket from idle starts probing after the clear
    if (!item.at_end && flags.phase == PH_IDLE && ch == CH_LBR) begin
      flags_next.phase = PH_PROBE;
    end
    if (fail) begin
      res_valid = 1'b1;
      res.out_char = '0;
      res.closes = 1'b0;
      res.status = fail_status;
    end
  end

endmodule

FILE: hw/rtl/bracket_literal_scanner.sv
// ----------------------------------------------------------------------------
// bracket_literal_scanner
// Scans a bracket-delimited literal one byte per item, passing characters
// through and reporting closure, imbalance and counter overflow.
// ----------------------------------------------------------------------------
// registers: each item is held in the input register, then its result loads into the
// result register when the step advances; a result not yet taken stalls the step
// throughput: one item per cycle while results are taken; the state update is a
// single step between the two registers
// reset (rst, synchronous): scanner returns to idle, both registers empty
module bracket_literal_scanner
  import bls_pkg::*;
#(
  parameter int MAX_CODE_LEVELS = DEF_MAX_CODE_LEVELS,
  parameter int MAX_PLAIN_DEPTH = DEF_MAX_PLAIN_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  localparam int CW = $clog2(MAX_CODE_LEVELS + 1);
  localparam int PW = $clog2(MAX_PLAIN_DEPTH + 1);

  logic          in_full;
  in_item_t      in_buf;
  flags_t        flags;
  flags_t        flags_next;
  logic [CW-1:0] code_levels;
  logic [CW-1:0] code_levels_next;
  logic [PW-1:0] plain_depth;
  logic [PW-1:0] plain_depth_next;
  logic          step_valid;
  out_item_t     step_res;
  logic          advance;

  assign advance = in_full && (!result_valid || result_ready);
  assign item_ready = !in_full || advance;

  bls_step #(
    .MAX_CODE_LEVELS(MAX_CODE_LEVELS),
    .MAX_PLAIN_DEPTH(MAX_PLAIN_DEPTH)
  ) u_step (
    .item             (in_buf),
    .flags            (flags),
    .code_levels      (code_levels),
    .plain_depth      (plain_depth),
    .flags_next       (flags_next),
    .code_levels_next (code_levels_next),
    .plain_depth_next (plain_depth_next),
    .res_valid        (step_valid),
    .res              (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      result_valid <= 1'b0;
      flags <= '{phase: PH_IDLE, escaping: 1'b0, in_comment: 1'b0};
      code_levels <= '0;
      plain_depth <= '0;
    end else begin
      if (item_valid && item_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        flags <= flags_next;
        code_levels <= code_levels_next;
        plain_depth <= plain_depth_next;
        result_valid <= step_valid;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) in_buf <= item;
    if (advance && step_valid) result <= step_res;
  end

  a_close_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.closes |-> result.status == ST_OK)
    else $error("closing result carries an error status");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.out_char == 8'd0)
    else $error("error result carries a character");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    advance && step_valid && (step_res.closes || step_res.status != ST_OK)
    |=> flags.phase == PH_IDLE && code_levels == '0 && plain_depth == '0)
    else $error("scanner not cleared after literal ended");

  a_depth_cap: assert property (@(posedge clk) disable iff (rst)
    plain_depth <= PW'(MAX_PLAIN_DEPTH) && code_levels <= CW'(MAX_CODE_LEVELS))
    else $error("counter beyond its limit");

endmodule
